// ===== sv/ofvo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofvo_pkg
// Shared constants, CORDIC arctangent table and saturation helper for the
// optical flow velocity observer.
// ----------------------------------------------------------------------------
package ofvo_pkg;

    localparam int STATE_FRAC_BITS_DEF = 16;
    localparam int COSINE_STEPS_DEF    = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_FLOW_SCALE    = 2'd0;
    localparam logic [1:0] CFG_OBSERVER_GAIN = 2'd1;
    localparam logic [1:0] CFG_TIME_STEP     = 2'd2;

    localparam logic [15:0] TIME_STEP_RST = 16'd66;

    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [39:0] Q30_ONE     = 40'sd1073741824;
    localparam logic signed [39:0] Q30_GAIN    = 40'sd652032874;
    localparam logic signed [60:0] DEN_HALF    = 61'sd536870912;

    // quotient of (height << 38) / den never exceeds 26 bits since den > 2^29
    localparam int DIV_BITS = 26;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:    atan_q30 = 30'h3243F6A8;
            5'd1:    atan_q30 = 30'h1DAC6705;
            5'd2:    atan_q30 = 30'h0FADBAFC;
            5'd3:    atan_q30 = 30'h07F56EA6;
            5'd4:    atan_q30 = 30'h03FEAB76;
            5'd5:    atan_q30 = 30'h01FFD55B;
            5'd6:    atan_q30 = 30'h00FFFAAA;
            5'd7:    atan_q30 = 30'h007FFF55;
            5'd8:    atan_q30 = 30'h003FFFEA;
            5'd9:    atan_q30 = 30'h001FFFFD;
            5'd10:   atan_q30 = 30'h000FFFFF;
            5'd11:   atan_q30 = 30'h0007FFFF;
            5'd12:   atan_q30 = 30'h0003FFFF;
            5'd13:   atan_q30 = 30'h0001FFFF;
            5'd14:   atan_q30 = 30'h0000FFFF;
            5'd15:   atan_q30 = 30'h00007FFF;
            5'd16:   atan_q30 = 30'h00003FFF;
            5'd17:   atan_q30 = 30'h00001FFF;
            5'd18:   atan_q30 = 30'h00000FFF;
            5'd19:   atan_q30 = 30'h000007FF;
            5'd20:   atan_q30 = 30'h000003FF;
            5'd21:   atan_q30 = 30'h000001FF;
            5'd22:   atan_q30 = 30'h000000FF;
            5'd23:   atan_q30 = 30'h0000007F;
            default: atan_q30 = 30'h0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/optical_flow_velocity_observer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// optical_flow_velocity_observer
// Horizontal velocity/position observer driven by optical flow measurements.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_valid / o_stall) carries one command transaction: a flow
//  measurement (command 0) or a position predict tick (command 1).
//  Output channel (o_valid / i_stall) returns one transaction per input with
//  the state after the update and the measurement_used flag.
//  One transaction is computed at a time; o_stall is high from acceptance
//  until the result is loaded into the output register, so the next input
//  can be taken while a result waits. A finished computation holds in the
//  output state while an older result is still stalled.
//  Flow item: two CORDIC cosines (an init step, then the rotations), the
//  product and tilt check, a restoring divider, the update steps and one
//  output load before o_valid. An item failing the tilt check skips the
//  divider and the update and goes straight to the output load.
//  Predict item: the update steps and the output load before o_valid.
//  Every multiply but the x32 scaling of the roll and pitch rates goes
//  through one registered 34x33 signed multiplier.
//  Reset (synchronous, active low) clears the estimates, loads register
//  defaults and empties the output. A stalled result holds its payload.
// ----------------------------------------------------------------------------
module optical_flow_velocity_observer
    import ofvo_pkg::*;
#(
    parameter int STATE_FRAC_BITS = STATE_FRAC_BITS_DEF,
    parameter int COSINE_STEPS    = COSINE_STEPS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_wr_en,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [15:0]        i_cfg_data,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire                i_command,
    input  wire  signed [15:0] i_roll_angle,
    input  wire  signed [15:0] i_pitch_angle,
    input  wire  signed [15:0] i_roll_rate,
    input  wire  signed [15:0] i_pitch_rate,
    input  wire  [15:0]        i_height,
    input  wire  signed [15:0] i_flow_count_x,
    input  wire  signed [15:0] i_flow_count_y,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_position_x,
    output logic signed [31:0] o_position_y,
    output logic signed [31:0] o_velocity_x,
    output logic signed [31:0] o_velocity_y,
    output logic               o_measurement_used
);

    localparam int IW         = $clog2(COSINE_STEPS + 1);
    localparam int MEAS_SHIFT = 32 - STATE_FRAC_BITS;

    typedef enum logic [4:0] {
        ST_IDLE, ST_COS_INIT, ST_COS_ITER, ST_DEN_MUL, ST_DEN_CHK, ST_DIV,
        ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_F8,
        ST_F9, ST_F10, ST_P0, ST_P1, ST_P2, ST_OUT
    } t_state;

    t_state r_state;

    logic [15:0] r_flow_scale, r_gain, r_dt;
    logic signed [31:0] r_vx, r_vy, r_px, r_py;
    logic r_used, r_out_valid;

    // output register
    logic signed [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy;
    logic r_o_used;

    // captured item
    logic signed [15:0] r_roll, r_pitch, r_rr, r_pr, r_cx, r_cy;
    logic [15:0] r_h;

    // cordic
    logic r_sel, r_refl;
    logic [IW-1:0] r_iter;
    logic signed [39:0] r_x, r_y;
    logic signed [35:0] r_z;
    logic signed [31:0] r_c0, r_c1;

    // divider
    logic [30:0] r_den;
    logic [31:0] r_rem;
    logic [DIV_BITS-1:0] r_q;
    logic [4:0] r_dcnt;

    logic signed [33:0] r_sum;
    logic signed [31:0] r_mx, r_my;
    logic [23:0] r_k;

    // shared multiplier
    logic signed [33:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [66:0] r_prod;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_DEN_MUL: begin
                w_ma = 34'(r_c0);
                w_mb = 33'(r_c1);
            end
            ST_F0: begin
                w_ma = $signed({18'd0, r_flow_scale});
                w_mb = 33'(r_cx);
            end
            ST_F3: begin
                w_ma = $signed({18'd0, r_flow_scale});
                w_mb = 33'(r_cy);
            end
            ST_F2, ST_F5: begin
                w_ma = r_sum;
                w_mb = $signed({7'd0, r_q});
            end
            ST_F6: begin
                w_ma = $signed({18'd0, r_gain});
                w_mb = $signed({17'd0, r_dt});
            end
            ST_F8: begin
                w_ma = $signed({10'd0, r_k});
                w_mb = 33'(r_mx) - 33'(r_vx);
            end
            ST_F9: begin
                w_ma = $signed({10'd0, r_k});
                w_mb = 33'(r_my) - 33'(r_vy);
            end
            ST_P0: begin
                w_ma = 34'(r_vx);
                w_mb = $signed({17'd0, r_dt});
            end
            ST_P1: begin
                w_ma = 34'(r_vy);
                w_mb = $signed({17'd0, r_dt});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // angle setup for the cosine being started: Q2.13 to Q2.30
    logic signed [15:0] w_ang;
    logic signed [33:0] w_a, w_abs;
    logic w_over;
    assign w_ang  = r_sel ? r_pitch : r_roll;
    assign w_a    = $signed({w_ang[15], w_ang, 17'd0});
    assign w_abs  = w_a[33] ? -w_a : w_a;
    assign w_over = 36'(w_abs) > Q30_HALF_PI;

    // one CORDIC rotation
    logic signed [39:0] w_xs, w_ys, w_xn;
    logic signed [35:0] w_atan;
    logic signed [39:0] w_xf, w_cc;
    assign w_xs   = r_x >>> r_iter;
    assign w_ys   = r_y >>> r_iter;
    assign w_atan = $signed({6'd0, atan_q30(5'(r_iter))});
    assign w_xn   = r_z[35] ? r_x + w_ys : r_x - w_ys;
    assign w_xf   = r_refl ? -w_xn : w_xn;
    assign w_cc   = (w_xf > Q30_ONE) ? Q30_ONE : ((w_xf < -Q30_ONE) ? -Q30_ONE : w_xf);

    // divider step
    logic [31:0] w_rem2;
    logic w_ge;
    assign w_rem2 = {r_rem[30:0], 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_den};

    logic signed [66:0] w_meas_sh, w_upd_sh;
    assign w_meas_sh = r_prod >>> MEAS_SHIFT;
    assign w_upd_sh  = r_prod >>> 16;

    assign o_stall            = (r_state != ST_IDLE);
    assign o_valid            = r_out_valid;
    assign o_position_x       = r_o_px;
    assign o_position_y       = r_o_py;
    assign o_velocity_x       = r_o_vx;
    assign o_velocity_y       = r_o_vy;
    assign o_measurement_used = r_o_used;

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_flow_scale <= '0;
            r_gain       <= '0;
            r_dt         <= TIME_STEP_RST;
            r_vx         <= '0;
            r_vy         <= '0;
            r_px         <= '0;
            r_py         <= '0;
            r_used       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_o_px       <= '0;
            r_o_py       <= '0;
            r_o_vx       <= '0;
            r_o_vy       <= '0;
            r_o_used     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FLOW_SCALE:    r_flow_scale <= i_cfg_data;
                    CFG_OBSERVER_GAIN: r_gain       <= i_cfg_data;
                    CFG_TIME_STEP:     r_dt         <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && (!r_out_valid || !i_stall))
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall)
                r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_roll  <= i_roll_angle;
                        r_pitch <= i_pitch_angle;
                        r_rr    <= i_roll_rate;
                        r_pr    <= i_pitch_rate;
                        r_h     <= i_height;
                        r_cx    <= i_flow_count_x;
                        r_cy    <= i_flow_count_y;
                        r_sel   <= 1'b0;
                        r_used  <= 1'b0;
                        r_state <= i_command ? ST_P0 : ST_COS_INIT;
                    end
                end
                ST_COS_INIT: begin
                    r_refl  <= w_over;
                    r_z     <= w_over ? Q30_PI - 36'(w_abs) : 36'(w_abs);
                    r_x     <= Q30_GAIN;
                    r_y     <= '0;
                    r_iter  <= '0;
                    r_state <= ST_COS_ITER;
                end
                ST_COS_ITER: begin
                    r_x <= w_xn;
                    if (r_z[35]) begin
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_atan;
                    end else begin
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_atan;
                    end
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == IW'(COSINE_STEPS - 1)) begin
                        if (r_sel) begin
                            r_c1    <= w_cc[31:0];
                            r_state <= ST_DEN_MUL;
                        end else begin
                            r_c0    <= w_cc[31:0];
                            r_sel   <= 1'b1;
                            r_state <= ST_COS_INIT;
                        end
                    end
                end
                ST_DEN_MUL: r_state <= ST_DEN_CHK;
                ST_DEN_CHK: begin
                    if ((r_prod >>> 30) > 67'(DEN_HALF)) begin
                        r_den   <= r_prod[60:30];
                        r_rem   <= {4'd0, r_h, 12'd0};
                        r_q     <= '0;
                        r_dcnt  <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    r_rem  <= w_ge ? w_rem2 - {1'b0, r_den} : w_rem2;
                    r_q    <= {r_q[DIV_BITS-2:0], w_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 5'(DIV_BITS - 1))
                        r_state <= ST_F0;
                end
                ST_F0: r_state <= ST_F1;
                ST_F1: begin
                    r_sum   <= r_prod[33:0] + 34'(r_pr) * 34'sd32;
                    r_state <= ST_F2;
                end
                ST_F2: r_state <= ST_F3;
                ST_F3: begin
                    r_mx    <= sat32(68'(w_meas_sh));
                    r_state <= ST_F4;
                end
                ST_F4: begin
                    r_sum   <= r_prod[33:0] - 34'(r_rr) * 34'sd32;
                    r_state <= ST_F5;
                end
                ST_F5: r_state <= ST_F6;
                ST_F6: begin
                    r_my    <= sat32(68'(w_meas_sh));
                    r_state <= ST_F7;
                end
                ST_F7: begin
                    r_k     <= r_prod[31:8];
                    r_state <= ST_F8;
                end
                ST_F8: r_state <= ST_F9;
                ST_F9: begin
                    r_vx    <= sat32(68'(r_vx) + 68'(w_upd_sh));
                    r_state <= ST_F10;
                end
                ST_F10: begin
                    r_vy    <= sat32(68'(r_vy) + 68'(w_upd_sh));
                    r_used  <= 1'b1;
                    r_state <= ST_OUT;
                end
                ST_P0: r_state <= ST_P1;
                ST_P1: begin
                    r_px    <= sat32(68'(r_px) + 68'(w_upd_sh));
                    r_state <= ST_P2;
                end
                ST_P2: begin
                    r_py    <= sat32(68'(r_py) + 68'(w_upd_sh));
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // wait for the output register to free up
                    if (!r_out_valid || !i_stall) begin
                        r_o_px   <= r_px;
                        r_o_py   <= r_py;
                        r_o_vx   <= r_vx;
                        r_o_vy   <= r_vy;
                        r_o_used <= r_used;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
